>>> rtl/srcw_pkg.sv
// ----------------------------------------------------------------------------
// srcw_pkg
// Types and constants shared by the chain writer controller and datapath.
// ----------------------------------------------------------------------------
package srcw_pkg;

  localparam int unsigned ShadowDepth        = 8;
  localparam int unsigned PosWidth           = 3;
  localparam int unsigned BitIdxWidth        = 3;
  localparam int unsigned ByteWidth          = 8;
  localparam int unsigned ChainLengthDefault = 8;

  localparam logic [BitIdxWidth-1:0] TopBit = BitIdxWidth'(ByteWidth - 1);

  typedef enum logic [0:0] {
    StIdle,
    StShift
  } srcw_state_e;

  typedef struct packed {
    logic start;
    logic advance;
  } srcw_cmd_t;

  typedef struct packed {
    logic in_range;
    logic last;
  } srcw_status_t;

endpackage

>>> rtl/srcw_ctrl.sv
// ----------------------------------------------------------------------------
// srcw_ctrl
// Controller: takes one write transaction at a time and paces the frame.
// ----------------------------------------------------------------------------
module srcw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  srcw_pkg::srcw_status_t status_i,
  output srcw_pkg::srcw_cmd_t    cmd_o
);
  import srcw_pkg::*;

  srcw_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && status_i.in_range) begin
          state_d = StShift;
        end
      end
      StShift: begin
        if (out_ready_i && status_i.last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o.start   = 1'b0;
    cmd_o.advance = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i && status_i.in_range;
      end
      StShift: begin
        out_valid_o   = 1'b1;
        cmd_o.advance = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // no new write while a frame is going out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken during a frame");

  // a started frame shows its first bit next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> out_valid_o)
    else $error("frame did not start");

  // a stalled bit keeps the frame running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("frame dropped under stall");

  // frame ends right after the final bit is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && status_i.last |=> in_ready_o)
    else $error("frame overran final bit");

endmodule

>>> rtl/srcw_dp.sv
// ----------------------------------------------------------------------------
// srcw_dp
// Datapath: shadow bytes, position and bit counters, serial bit selection.
// ----------------------------------------------------------------------------
module srcw_dp #(
  parameter int unsigned CHAIN_LENGTH = srcw_pkg::ChainLengthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  srcw_pkg::srcw_cmd_t                  cmd_i,
  output srcw_pkg::srcw_status_t               status_o,
  input  logic [srcw_pkg::ByteWidth-1:0]       position_i,
  input  logic [srcw_pkg::ByteWidth-1:0]       new_byte_i,
  output logic                                serial_bit_o,
  output logic [srcw_pkg::PosWidth-1:0]        source_position_o,
  output logic [srcw_pkg::BitIdxWidth-1:0]     bit_number_o,
  output logic                                final_bit_o
);
  import srcw_pkg::*;

  localparam logic [ByteWidth-1:0] ChainLen = ByteWidth'(CHAIN_LENGTH);
  localparam logic [PosWidth-1:0]  LastPos  = PosWidth'(CHAIN_LENGTH - 1);

  logic [ByteWidth-1:0]   shadow_q [ShadowDepth];
  logic [PosWidth-1:0]    pos_q, pos_d;
  logic [BitIdxWidth-1:0] bit_q, bit_d;
  logic                   last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ShadowDepth; i++) begin
        shadow_q[i] <= '0;
      end
    end else if (cmd_i.start) begin
      shadow_q[position_i[PosWidth-1:0]] <= new_byte_i;
    end
  end

  always_comb begin
    pos_d = pos_q;
    bit_d = bit_q;
    if (cmd_i.start) begin
      pos_d = '0;
      bit_d = TopBit;
    end else if (cmd_i.advance) begin
      if (bit_q == '0) begin
        bit_d = TopBit;
        pos_d = pos_q + PosWidth'(1);
      end else begin
        bit_d = bit_q - BitIdxWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      bit_q <= TopBit;
    end else begin
      pos_q <= pos_d;
      bit_q <= bit_d;
    end
  end

  assign last              = (pos_q == LastPos) && (bit_q == '0);
  assign status_o.in_range = position_i < ChainLen;
  assign status_o.last     = last;

  assign serial_bit_o      = shadow_q[pos_q][bit_q];
  assign source_position_o = pos_q;
  assign bit_number_o      = bit_q;
  assign final_bit_o       = last;

endmodule

>>> rtl/shift_register_chain_writer.sv
// ----------------------------------------------------------------------------
// Latency: the first bit of a frame is offered the cycle after a write is taken.
// Throughput: CHAIN_LENGTH*8 bits per frame, one per cycle while the sink is ready;
// the bit counter paces the frame.
// An out-of-range position is taken and gives no bits.
// Reset clears all shadow bytes to zero at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// shift_register_chain_writer
// Stores one byte per chained output register and shifts the chain out.
// ----------------------------------------------------------------------------
module shift_register_chain_writer #(
  parameter int unsigned CHAIN_LENGTH = srcw_pkg::ChainLengthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [srcw_pkg::ByteWidth-1:0]   position_i,
  input  logic [srcw_pkg::ByteWidth-1:0]   new_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            serial_bit_o,
  output logic [srcw_pkg::PosWidth-1:0]    source_position_o,
  output logic [srcw_pkg::BitIdxWidth-1:0] bit_number_o,
  output logic                            final_bit_o
);
  import srcw_pkg::*;

  srcw_cmd_t    cmd;
  srcw_status_t status;

  srcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  srcw_dp #(
    .CHAIN_LENGTH (CHAIN_LENGTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .position_i        (position_i),
    .new_byte_i        (new_byte_i),
    .serial_bit_o      (serial_bit_o),
    .source_position_o (source_position_o),
    .bit_number_o      (bit_number_o),
    .final_bit_o       (final_bit_o)
  );

endmodule
